[sv/cbf_pkg.sv]
// Shared constants, types and constant functions of the crystal ball evaluator.
package cbf_pkg;

	localparam int DW = 32;               // register and data width
	localparam int FB = 16;               // fraction bits of the ports
	localparam int QF = 24;               // fraction bits inside
	localparam int SHQ = QF - FB;         // port to internal shift
	localparam int NUMW = DW + QF;        // dividend and quotient width
	localparam int A24W = DW + SHQ;       // |alpha| in Q.24
	localparam int NPW = DW - 1;          // tail power width
	localparam int SQB = 28;              // square input bits before overflow
	localparam int SQ_SH = 25;            // (v*v) >> 25 is v^2/2
	localparam int SQW = 2 * SQB - SQ_SH; // half square width
	localparam int L2EW = 31;
	localparam int L2E_SH = 30;
	localparam logic [L2EW-1:0] LOG2E_Q30 = 31'd1549082005;
	localparam int YW = 32;               // exponent width
	localparam int NW = 64;               // normalizer width
	localparam int KB = 6;                // bit position width
	localparam int NORM_STEPS = 6;
	localparam int MW = 32;               // Q.31 mantissa
	localparam int LOG_STEPS = QF;
	localparam int LGW = 31;
	localparam int LGX = 32;
	localparam int PPW = NPW + LGW;
	localparam int TAIL_B = 47;           // n*lg beyond 2^55 in Q.24 terms
	localparam int YT_SH = QF - SHQ;
	localparam int ACCW = 32;
	localparam int ACC_FB = 31;
	localparam int EXP_STEPS = QF;
	localparam int KZ = QF + KB;          // y at or above 2^30 gives zero
	localparam int KMAX = 2 * ACCW - ACC_FB - 1;
	localparam int SUMW = 2 * ACCW + 1;
	localparam int MAGW = SUMW - ACC_FB;
	localparam int REG_IDX_W = 3;

	localparam logic [DW-1:0] RST_ALPHA = DW'(66191);
	localparam logic [NPW-1:0] RST_POWER = NPW'(131072);
	localparam logic [DW-1:0] RST_MEAN = DW'(65536);
	localparam logic [DW-1:0] RST_SIGMA = DW'(1966);
	localparam logic [DW-1:0] RST_NORM = DW'(65536);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ALPHA = 3'd0,
		REG_POWER = 3'd1,
		REG_MEAN  = 3'd2,
		REG_SIGMA = 3'd3,
		REG_NORM  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [DW-1:0]   rem;
		logic [NUMW-1:0] numq;
	} div_st_t;

	typedef struct packed {
		logic [MW-1:0] m;
		logic [QF-1:0] f;
	} log_st_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		logic [63:0] r;
		r = v;
		res = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > r)
				b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != '0) begin
				if (r >= res + b) begin
					r = r - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// factor 2^(-2^-(j+1)) in Q.31, each one the root of the one before
	function automatic logic [ACCW-1:0] exp_factor(input int j);
		logic [63:0] c;
		c = 64'd1 << 30;
		for (int i = 0; i < EXP_STEPS; i++) begin
			if (i <= j)
				c = isqrt64(c << 31);
		end
		return c[ACCW-1:0];
	endfunction

endpackage

[sv/cbf_chan_if.sv]
// Input and result channel interfaces of the crystal ball evaluator.
interface cbf_in_if import cbf_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DW-1:0] x_value;
	modport source(output valid, output x_value, input ready);
	modport sink(input valid, input x_value, output ready);
endinterface

interface cbf_out_if import cbf_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DW-1:0] shape_value;
	status_t eval_status;
	modport source(output valid, output shape_value, output eval_status, input ready);
	modport sink(input valid, input shape_value, input eval_status, output ready);
endinterface

[sv/cbf_div_cell.sv]
// One restoring division step: one quotient bit per cell.
module cbf_div_cell import cbf_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] den,
	input  div_st_t       d_in,
	output div_st_t       d_out
);

	logic [DW:0] r2;
	logic [DW:0] rdiff;
	logic        ge;

	assign r2 = {d_in.rem, d_in.numq[NUMW-1]};
	assign rdiff = r2 - {1'b0, den};
	assign ge = r2 >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.rem <= ge ? rdiff[DW-1:0] : r2[DW-1:0];
			d_out.numq <= {d_in.numq[NUMW-2:0], ge};
		end
	end

endmodule

[sv/cbf_log_cell.sv]
// One log2 fraction bit: square the mantissa and renormalize.
module cbf_log_cell import cbf_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  log_st_t l_in,
	output log_st_t l_out
);

	logic [2*MW-1:0] sq;
	logic [MW:0]     m2;

	assign sq = l_in.m * l_in.m;
	assign m2 = sq[2*MW-1:MW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			l_out.m <= m2[MW] ? m2[MW:1] : m2[MW-1:0];
			l_out.f <= {l_in.f[QF-2:0], m2[MW]};
		end
	end

endmodule

[sv/cbf_exp_cell.sv]
// One 2^-f factor: multiply in this cell's root when its bit is set.
module cbf_exp_cell import cbf_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [ACCW-1:0] factor,
	input  logic            use_fac,
	input  logic [ACCW-1:0] acc_in,
	output logic [ACCW-1:0] acc_out
);

	logic [2*ACCW-1:0] prod;

	assign prod = acc_in * factor;

	always_ff @(posedge clk) begin
		if (en)
			acc_out <= use_fac ? prod[ACC_FB +: ACCW] : acc_in;
	end

endmodule

[sv/crystal_ball_function_eval_unit.sv]
// Top level of the crystal ball evaluator: config registers and the cell pipeline.
//
//   channel  | dir | handshake     | payload
//   point    | in  | valid / ready | x_value
//   result   | out | valid / ready | shape_value, eval_status
//   cfg      | in  | cfg_we        | cfg_index, cfg_wdata
//
// One item per cycle while the result is not stalled; the pipe is built of the 56 divider cells,
// 6 normalize stages, 24 log squaring cells and 24 exponent factor cells.
// arst_n clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipe; the next item is still taken in
// any cycle where the result register is empty or being read.
module crystal_ball_function_eval_unit import cbf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DW-1:0]        cfg_wdata,
	cbf_in_if.sink               point,
	cbf_out_if.source            result
);

	typedef struct packed {
		logic          tail;
		logic          big;
		logic [YW-1:0] y0;
	} core_side_t;

	typedef struct packed {
		core_side_t    c;
		logic [KB-1:0] pw;
		logic [KB-1:0] pu;
	} log_side_t;

	typedef struct packed {
		logic          zero;
		logic [KB-1:0] k;
		logic [QF-1:0] f;
	} exp_side_t;

	localparam logic [MAGW-1:0] MAG_POS = {{(MAGW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [MAGW-1:0] MAG_NEG = {{(MAGW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

	logic [DW-1:0]  alpha_q, mean_q, sigma_q, norm_q;
	logic [NPW-1:0] power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= RST_ALPHA;
			power_q <= RST_POWER;
			mean_q <= RST_MEAN;
			sigma_q <= RST_SIGMA;
			norm_q <= RST_NORM;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ALPHA: alpha_q <= cfg_wdata;
				REG_POWER: power_q <= cfg_wdata[NPW-1:0];
				REG_MEAN:  mean_q <= cfg_wdata;
				REG_SIGMA: sigma_q <= cfg_wdata;
				REG_NORM:  norm_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic          aneg, sneg, nneg, cfg_zero;
	logic [DW-1:0] amag, smag, nmag;

	assign aneg = alpha_q[DW-1];
	assign sneg = sigma_q[DW-1];
	assign nneg = norm_q[DW-1];
	assign amag = aneg ? (~alpha_q + 1'b1) : alpha_q;
	assign smag = sneg ? (~sigma_q + 1'b1) : sigma_q;
	assign nmag = nneg ? (~norm_q + 1'b1) : norm_q;
	assign cfg_zero = (amag == '0) || (smag == '0);

	logic [A24W-1:0] a24;
	logic [NUMW-1:0] a24x;
	assign a24 = {amag, {SHQ{1'b0}}};
	assign a24x = NUMW'(a24);

	logic en, accept, vld_s10;
	assign en = !vld_s10 || result.ready;
	assign point.ready = en;
	assign accept = point.valid && en;

	// front: |x - mean| and its sign
	logic [DW-1:0] xb, mb, diff;
	logic          dneg_in;
	assign xb = point.x_value ^ {1'b1, {(DW-1){1'b0}}};
	assign mb = mean_q ^ {1'b1, {(DW-1){1'b0}}};
	assign dneg_in = xb < mb;
	assign diff = dneg_in ? (mb - xb) : (xb - mb);

	div_st_t       dt [NUMW+1];
	div_st_t       du [NUMW+1];
	logic [NUMW:0] dvld_s;
	logic [NUMW:0] dneg_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dvld_s <= '0;
		else if (en)
			dvld_s <= {dvld_s[NUMW-1:0], accept};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s <= {dneg_s[NUMW-1:0], dneg_in};
			dt[0] <= '{rem: '0, numq: {diff, {QF{1'b0}}}};
			du[0] <= '{rem: '0, numq: {1'b0, power_q, {QF{1'b0}}}};
		end
	end

	for (genvar i = 0; i < NUMW; i++) begin : g_div
		cbf_div_cell u_div_t (.clk(clk), .en(en), .den(smag), .d_in(dt[i]), .d_out(dt[i+1]));
		cbf_div_cell u_div_u (.clk(clk), .en(en), .den(amag), .d_in(du[i]), .d_out(du[i+1]));
	end

	// pick core or tail
	logic [NUMW-1:0] tm, u_raw, uc;
	logic            tneg, tail;
	assign tm = dt[NUMW].numq;
	assign u_raw = du[NUMW].numq;
	assign uc = (u_raw == '0) ? NUMW'(1) : u_raw;
	assign tneg = (dneg_s[NUMW] ^ sneg ^ aneg) && (tm != '0);
	assign tail = tneg && (tm > a24x);

	logic            vld_s2, tail_s2;
	logic [NUMW-1:0] tm_s2, uc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s2 <= tail;
			tm_s2 <= tm;
			uc_s2 <= uc;
		end
	end

	// half square of |t| or |alpha|, and u + d for the tail log
	logic [NUMW-1:0]  sqv;
	logic [2*SQB-1:0] sqp;
	assign sqv = tail_s2 ? a24x : tm_s2;
	assign sqp = sqv[SQB-1:0] * sqv[SQB-1:0];

	logic            vld_s3, tail_s3, big_s3;
	logic [SQW-1:0]  sq_s3;
	logic [NUMW:0]   w_s3;
	logic [NUMW-1:0] u_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s3 <= tail_s2;
			big_s3 <= sqv[NUMW-1:SQB] != '0;
			sq_s3 <= sqp[2*SQB-1:SQ_SH];
			w_s3 <= {1'b0, uc_s2} + {1'b0, tm_s2} - {1'b0, a24x};
			u_s3 <= uc_s2;
		end
	end

	logic [SQW+L2EW-1:0] y0p;
	assign y0p = sq_s3 * LOG2E_Q30;

	// leading one search over the two log arguments
	logic [NW-1:0]    nw [NORM_STEPS+1];
	logic [NW-1:0]    nu [NORM_STEPS+1];
	logic [KB-1:0]    cw [NORM_STEPS+1];
	logic [KB-1:0]    cu [NORM_STEPS+1];
	core_side_t       cs [NORM_STEPS+1];
	logic [NORM_STEPS:1] nvld_s;

	assign nw[0] = NW'(w_s3);
	assign nu[0] = NW'(u_s3);
	assign cw[0] = '0;
	assign cu[0] = '0;
	assign cs[0] = '{tail: tail_s3, big: big_s3, y0: y0p[SQW+L2EW-1:L2E_SH]};

	for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
		localparam int SH = (NW / 2) >> g;
		always_ff @(posedge clk) begin
			if (en) begin
				cs[g+1] <= cs[g];
				if (nw[g][NW-1 -: SH] == '0) begin
					nw[g+1] <= nw[g] << SH;
					cw[g+1] <= cw[g] + KB'(SH);
				end else begin
					nw[g+1] <= nw[g];
					cw[g+1] <= cw[g];
				end
				if (nu[g][NW-1 -: SH] == '0) begin
					nu[g+1] <= nu[g] << SH;
					cu[g+1] <= cu[g] + KB'(SH);
				end else begin
					nu[g+1] <= nu[g];
					cu[g+1] <= cu[g];
				end
			end
		end
	end

	log_st_t            lw [LOG_STEPS+1];
	log_st_t            lu [LOG_STEPS+1];
	log_side_t          ls [LOG_STEPS+1];
	logic [LOG_STEPS:1] lvld_s;

	// bit position is 63 minus the shift count
	assign lw[0] = '{m: nw[NORM_STEPS][NW-1 -: MW], f: '0};
	assign lu[0] = '{m: nu[NORM_STEPS][NW-1 -: MW], f: '0};
	assign ls[0] = '{c: cs[NORM_STEPS], pw: ~cw[NORM_STEPS], pu: ~cu[NORM_STEPS]};

	for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
		cbf_log_cell u_log_w (.clk(clk), .en(en), .l_in(lw[i]), .l_out(lw[i+1]));
		cbf_log_cell u_log_u (.clk(clk), .en(en), .l_in(lu[i]), .l_out(lu[i+1]));
		always_ff @(posedge clk) begin
			if (en)
				ls[i+1] <= ls[i];
		end
	end

	logic [LGX-1:0] lgx;
	assign lgx = ((LGX'(ls[LOG_STEPS].pw) - LGX'(ls[LOG_STEPS].pu)) << QF)
		+ LGX'(lw[LOG_STEPS].f) - LGX'(lu[LOG_STEPS].f);

	logic           vld_s5, vld_s6;
	core_side_t     c_s5, c_s6;
	logic [LGW-1:0] lg_s5;
	logic [PPW-1:0] pp_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5 <= ls[LOG_STEPS].c;
			lg_s5 <= lgx[LGW-1:0];
			c_s6 <= c_s5;
			pp_s6 <= power_q * lg_s5;
		end
	end

	// total exponent y; drop to zero when it is out of range
	logic          ytbig;
	logic [YW-1:0] yt;
	logic [YW:0]   ysum;
	assign ytbig = pp_s6 > (PPW'(1) << TAIL_B);
	assign yt = pp_s6[YT_SH +: YW];
	assign ysum = c_s6.tail ? ({1'b0, c_s6.y0} + {1'b0, yt}) : {1'b0, c_s6.y0};

	exp_side_t          es [EXP_STEPS+1];
	logic [ACCW-1:0]    acc [EXP_STEPS+1];
	logic [EXP_STEPS:0] evld_s;

	assign acc[0] = {1'b1, {(ACCW-1){1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			es[0].zero <= c_s6.big || (c_s6.tail && ytbig) || (ysum[YW:KZ] != '0);
			es[0].k <= ysum[KZ-1:QF];
			es[0].f <= ysum[QF-1:0];
		end
	end

	for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
		cbf_exp_cell u_exp (
			.clk(clk), .en(en), .factor(exp_factor(j)), .use_fac(es[j].f[QF-1-j]),
			.acc_in(acc[j]), .acc_out(acc[j+1])
		);
		always_ff @(posedge clk) begin
			if (en)
				es[j+1] <= es[j];
		end
	end

	logic               vld_s8, zero_s8, vld_s9, zero_s9;
	logic [KB-1:0]      k_s8, k_s9;
	logic [DW+ACCW-1:0] p2_s8;
	logic [SUMW-1:0]    sum_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s8 <= es[EXP_STEPS].zero;
			k_s8 <= es[EXP_STEPS].k;
			p2_s8 <= nmag * acc[EXP_STEPS];
			zero_s9 <= zero_s8 || (k_s8 > KB'(KMAX));
			k_s9 <= k_s8;
			sum_s9 <= SUMW'(p2_s8) + (SUMW'(1) << (7'(ACC_FB - 1) + 7'(k_s8)));
		end
	end

	// round, scale and clamp into the signed range
	logic [MAGW-1:0] mag;
	logic [DW-1:0]   shape_d;
	status_t         status_d;

	always_comb begin
		mag = zero_s9 ? '0 : (sum_s9[SUMW-1:ACC_FB] >> k_s9);
		status_d = ST_OK;
		shape_d = nneg ? (~mag[DW-1:0] + 1'b1) : mag[DW-1:0];
		if (cfg_zero) begin
			shape_d = '0;
			status_d = ST_ZERO;
		end else if (!nneg && mag > MAG_POS) begin
			shape_d = MAG_POS[DW-1:0];
			status_d = ST_SAT;
		end else if (nneg && mag > MAG_NEG) begin
			shape_d = MAG_NEG[DW-1:0];
			status_d = ST_SAT;
		end
	end

	logic [DW-1:0] shape_s10;
	status_t       status_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			shape_s10 <= shape_d;
			status_s10 <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			nvld_s <= '0;
			lvld_s <= '0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			evld_s <= '0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s2 <= dvld_s[NUMW];
			vld_s3 <= vld_s2;
			nvld_s <= {nvld_s[NORM_STEPS-1:1], vld_s3};
			lvld_s <= {lvld_s[LOG_STEPS-1:1], nvld_s[NORM_STEPS]};
			vld_s5 <= lvld_s[LOG_STEPS];
			vld_s6 <= vld_s5;
			evld_s <= {evld_s[EXP_STEPS-1:0], vld_s6};
			vld_s8 <= evld_s[EXP_STEPS];
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	assign result.valid = vld_s10;
	assign result.shape_value = shape_s10;
	assign result.eval_status = status_s10;

endmodule

[tb/tb_crystal_ball_function_eval_unit.sv]
// Self-checking testbench of the crystal ball evaluator: directed table, random phases.
module tb_crystal_ball_function_eval_unit;
	import cbf_pkg::*;

	localparam logic [REG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
	localparam logic [REG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam longint unsigned DMASK = 64'hFFFF_FFFF;
	localparam longint unsigned SIGNB = 64'h8000_0000;
	localparam longint unsigned QCAP = 64'd1 << 62;
	localparam longint unsigned YBIG = 64'd1 << 31;
	localparam longint unsigned L2E = 64'd1549082005;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		logic [DW-1:0] shape;
		status_t st;
	} shape_res_t;

	typedef struct {
		bit is_cfg;
		logic [REG_IDX_W-1:0] idx;
		logic [DW-1:0] val;
		bit fixed;
		logic [DW-1:0] shape;
		status_t st;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_wdata = '0;

	cbf_in_if point();
	cbf_out_if result();

	crystal_ball_function_eval_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .point(point), .result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [DW-1:0] m_alpha = RST_ALPHA, m_power = DW'(RST_POWER), m_mean = RST_MEAN;
	logic [DW-1:0] m_sigma = RST_SIGMA, m_norm = RST_NORM;
	shape_res_t shape_q[$];
	int errors = 0;
	int snd_idle = 28;
	int rcv_idle = 57;
	int stall_cnt = 0;

	function automatic longint unsigned magnitude(input logic [DW-1:0] v);
		return v[DW-1] ? ((~longint'(v)) + 1) & DMASK : longint'(v);
	endfunction

	function automatic longint unsigned quot_q24(input longint unsigned num, den);
		longint unsigned q, rem, f;
		q = num / den;
		rem = num % den;
		f = 0;
		if (q >= (64'd1 << 38))
			return QCAP;
		for (int i = 0; i < 24; i++) begin
			f = f << 1;
			if (rem >= den - rem) begin
				f |= 1;
				rem -= den - rem;
			end else begin
				rem += rem;
			end
		end
		return (q << 24) | f;
	endfunction

	function automatic longint unsigned widen_q24(input longint unsigned v);
		longint unsigned r;
		if (v == 0)
			return 0;
		r = (v >= (QCAP >> 8)) ? QCAP : (v << 8);
		if (r > QCAP)
			r = QCAP;
		return (r == 0) ? 1 : r;
	endfunction

	function automatic longint log2_fix(input longint unsigned v);
		int p;
		longint unsigned m, f;
		p = 63;
		f = 0;
		while (p > 0 && !v[p])
			p--;
		m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 31;
			f = f << 1;
			if (m >= (64'd1 << 32)) begin
				f |= 1;
				m = m >> 1;
			end
		end
		return (longint'(p) - 24) * 16777216 + longint'(f);
	endfunction

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// |norm| * 2^-y, rounded half up
	function automatic longint unsigned attenuate(input longint unsigned nm, y);
		longint unsigned k, f, acc, c;
		logic [127:0] prod;
		int s;
		k = y >> 24;
		f = y & 64'hFF_FFFF;
		acc = 64'd1 << 31;
		c = 64'd1 << 30;
		if (k >= 64)
			return 0;
		for (int i = 23; i >= 0; i--) begin
			c = int_root(c << 31);
			if (f[i])
				acc = (acc * c) >> 31;
		end
		s = 31 + int'(k);
		prod = 128'(nm) * 128'(acc) + (128'd1 << (s - 1));
		return 64'(prod >> s);
	endfunction

	function automatic shape_res_t predict_shape(input logic [DW-1:0] x);
		shape_res_t r;
		longint unsigned amag, smag, nm, xb, mb, diff, tm, a24, y, mag;
		longint unsigned ya, yt, nraw, u, d, n24, lg;
		bit dneg, tneg;
		amag = magnitude(m_alpha);
		smag = magnitude(m_sigma);
		nm = magnitude(m_norm);
		r.st = ST_OK;
		if (amag == 0 || smag == 0) begin
			r.shape = '0;
			r.st = ST_ZERO;
			return r;
		end
		xb = longint'(x) ^ SIGNB;
		mb = longint'(m_mean) ^ SIGNB;
		dneg = xb < mb;
		diff = dneg ? mb - xb : xb - mb;
		tm = quot_q24(diff, smag);
		tneg = (dneg != m_sigma[DW-1]) != m_alpha[DW-1];
		if (tm == 0)
			tneg = 1'b0;
		a24 = widen_q24(amag);
		if (!tneg || tm <= a24) begin
			y = (tm >= (64'd1 << 28)) ? YBIG : ((((tm * tm) >> 25) * L2E) >> 30);
		end else if (a24 >= (64'd1 << 28)) begin
			y = YBIG;
		end else begin
			ya = (((a24 * a24) >> 25) * L2E) >> 30;
			yt = 0;
			nraw = longint'(m_power) & (DMASK >> 1);
			if (nraw != 0) begin
				u = quot_q24(nraw, amag);
				if (u == 0)
					u = 1;
				d = tm - a24;
				n24 = widen_q24(nraw);
				lg = longint'(log2_fix(u + d) - log2_fix(u));
				if (lg != 0 && n24 > ((64'd1 << 55) / lg))
					yt = YBIG;
				else
					yt = (n24 * lg) >> 24;
			end
			y = ya + yt;
		end
		mag = (y >= YBIG) ? 0 : attenuate(nm, y);
		if (!m_norm[DW-1] && mag > SIGNB - 1) begin
			mag = SIGNB - 1;
			r.st = ST_SAT;
		end
		if (m_norm[DW-1] && mag > SIGNB) begin
			mag = SIGNB;
			r.st = ST_SAT;
		end
		r.shape = m_norm[DW-1] ? DW'(~mag + 1) : DW'(mag);
		return r;
	endfunction

	// result side: check, stall at random, watch for a hang
	always @(posedge clk) begin
		shape_res_t want;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (shape_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h status %0d",
							result.shape_value, result.eval_status);
				end else begin
					want = shape_q.pop_front();
					if (want.shape !== result.shape_value || want.st !== result.eval_status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h/%0d got %h/%0d", want.shape,
								want.st, result.shape_value, result.eval_status);
					end
				end
			end
			if ((result.valid && result.ready) || (point.valid && point.ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("crystal_ball_function_eval_unit test failed");
				$finish;
			end
		end
		result.ready <= ($urandom_range(99) >= rcv_idle);
	end

	task automatic send_point(input logic [DW-1:0] x, input bit fixed,
			input shape_res_t given);
		while ($urandom_range(99) < snd_idle) begin
			point.valid <= 1'b0;
			@(posedge clk);
		end
		point.valid <= 1'b1;
		point.x_value <= x;
		do
			@(posedge clk);
		while (!point.ready);
		shape_q.push_back(fixed ? given : predict_shape(x));
	endtask

	task automatic drain();
		point.valid <= 1'b0;
		@(posedge clk);
		while (shape_q.size() != 0)
			@(posedge clk);
	endtask

	// write only with the pipe empty
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DW-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ALPHA: m_alpha = val;
			REG_POWER: m_power = val & 32'h7FFF_FFFF;
			REG_MEAN:  m_mean = val;
			REG_SIGMA: m_sigma = val;
			REG_NORM:  m_norm = val;
			default: ;
		endcase
	endtask

	function automatic logic [DW-1:0] pick_x();
		int mode;
		longint off;
		mode = $urandom_range(99);
		if (mode < 55) begin
			off = longint'($signed(m_sigma)) * (longint'($urandom_range(8000)) - 4000) / 100;
			return DW'(longint'($signed(m_mean)) + off);
		end else if (mode < 80) begin
			return $urandom;
		end
		return m_mean + DW'($urandom_range(64)) - DW'(32);
	endfunction

	function automatic logic [DW-1:0] pick_signed(input int lo, hi);
		logic [DW-1:0] v;
		v = DW'($urandom_range(hi, lo));
		return $urandom_range(1) ? -v : v;
	endfunction

	stim_row_t rows[$];
	shape_res_t none;

	initial begin
		none = '{shape: '0, st: ST_OK};
		point.valid = 1'b0;
		point.x_value = '0;
		result.ready = 1'b0;
		rows = '{
			'{0, REG_ALPHA, 32'd65536, 1, 32'd65536, ST_OK},
			'{0, REG_ALPHA, 32'h8000_0000, 1, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'h7FFF_FFFF, 1, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd65436, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd62536, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd68536, 0, 32'd0, ST_OK},
			'{1, REG_NORM, 32'h8000_0000, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd65536, 1, 32'h8000_0000, ST_OK},
			'{1, REG_NORM, 32'h7FFF_FFFF, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd65536, 1, 32'h7FFF_FFFF, ST_OK},
			'{1, REG_POWER, 32'd0, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd62536, 0, 32'd0, ST_OK},
			'{1, REG_POWER, 32'h7FFF_FFFF, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd63536, 0, 32'd0, ST_OK},
			'{1, REG_POWER, 32'd1, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd62000, 0, 32'd0, ST_OK},
			'{1, REG_ALPHA, 32'hFFFE_FD71, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd68536, 0, 32'd0, ST_OK},
			'{1, REG_ALPHA, 32'h7FFF_FFFF, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd62536, 0, 32'd0, ST_OK},
			'{1, REG_ALPHA, 32'd0, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd1234, 1, 32'd0, ST_ZERO},
			'{1, IDX_SPARE_LO, 32'd65536, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'hFFFF_0000, 1, 32'd0, ST_ZERO},
			'{1, REG_ALPHA, 32'h8000_0000, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd60000, 0, 32'd0, ST_OK},
			'{1, REG_SIGMA, 32'd0, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd65536, 1, 32'd0, ST_ZERO},
			'{1, IDX_SPARE_HI, 32'd7, 0, 32'd0, ST_OK},
			'{1, REG_SIGMA, 32'h8000_0000, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'd65536, 0, 32'd0, ST_OK},
			'{1, REG_MEAN, 32'h8000_0000, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'h7FFF_FFFF, 0, 32'd0, ST_OK},
			'{1, REG_MEAN, 32'h7FFF_FFFF, 0, 32'd0, ST_OK},
			'{0, REG_ALPHA, 32'h8000_0000, 0, 32'd0, ST_OK}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_reg(rows[i].idx, rows[i].val);
			else
				send_point(rows[i].val, rows[i].fixed, '{shape: rows[i].shape, st: rows[i].st});
		end

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 3) begin
				snd_idle = 57;
				rcv_idle = 28;
			end else if (ph == 6) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			write_reg(REG_ALPHA, (ph == 7) ? 32'h7FFF_FFFF : pick_signed(32'h800, 32'h50000));
			write_reg(REG_POWER, (ph == 2) ? 32'h7FFF_FFFF :
				($urandom_range(3) == 0 ? $urandom : DW'($urandom_range(32'hA0000, 32'h800))));
			write_reg(REG_MEAN, $urandom_range(1) ? $urandom : pick_signed(0, 32'h80000));
			write_reg(REG_SIGMA, (ph == 5) ? 32'h8000_0000 : pick_signed(1, 32'h40000));
			write_reg(REG_NORM, (ph == 4) ? 32'h8000_0000 : $urandom);
			for (int n = 0; n < 81; n++) begin
				// once in phase 1, before the 41st point, hold off until the pipe is empty
				if (ph == 1 && n == 40)
					drain();
				send_point(pick_x(), 1'b0, none);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && shape_q.size() == 0)
			$display("crystal_ball_function_eval_unit test passed");
		else
			$display("crystal_ball_function_eval_unit test failed");
		$finish;
	end

endmodule

[files.f]
sv/cbf_pkg.sv
sv/cbf_chan_if.sv
sv/cbf_div_cell.sv
sv/cbf_log_cell.sv
sv/cbf_exp_cell.sv
sv/crystal_ball_function_eval_unit.sv
tb/tb_crystal_ball_function_eval_unit.sv
